FILE: rtl/bed_pkg.sv
// Shared constants, types and the window evaluation for the binary erode/dilate core.
package bed_pkg;

    localparam int WIDTH  = 16;
    localparam int HEIGHT = 16;

    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int BITS_W = 16;
    localparam int ADDR_W = $clog2(HEIGHT);
    localparam int MASK_W = 9;
    localparam int CFG_W  = MASK_W;
    localparam int IDX_W  = 1;

    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(HEIGHT - 1);
    localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(WIDTH - 1);
    localparam logic [MASK_W-1:0] SE_MASK_RESET = MASK_W'(56);

    localparam logic [IDX_W-1:0] CFG_OP_MODE = 1'b0;
    localparam logic [IDX_W-1:0] CFG_SE_MASK = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WIDTH-1:0]  wdata;
    } mem_req_t;

    // Bit k of win is the pixel at offset ((k / 3) - 1, (k % 3) - 1) from the centre.
    function automatic logic morph_eval(input logic [8:0] win, input logic mode,
                                        input logic [MASK_W-1:0] mask);
        logic [8:0] refl;
        logic       res;
        for (int k = 0; k < 9; k++) begin
            refl[k] = win[8 - k];
        end
        if (mode == MODE_DILATE) begin
            res = |(refl & mask);
        end
        else begin
            res = &(win | ~mask);
        end
        return res;
    endfunction

endpackage

FILE: rtl/bed_image_mem.sv
// Single-port image row memory with registered read and per-row valid bits.
module bed_image_mem
    import bed_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mem_req_t         req,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0]  mem_array [HEIGHT];
    logic [HEIGHT-1:0] valid_reg;
    logic [WIDTH-1:0]  rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.addr] <= req.wdata;
        end
        rd_data_reg <= mem_array[req.addr];
    end

    // A row never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/binary_erode_dilate_core.sv
// Top level of the binary 3x3 erosion/dilation core.
// Rows are loaded one word per transaction; input is ready again at once. A query closes
// the input until its result is registered. On an interior position the single-port image
// memory returns the rows above, at and below the queried row one per cycle, and the result
// is registered as the third row arrives. A query on a border row or column gives 0. A
// finished result waits in the output register; the core holds its last query step only
// while that register is still occupied. The image is zero after reset without any clearing
// pass.
module binary_erode_dilate_core
    import bed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // row[3:0], col[7:4], row_bits[23:8]
    input  logic              s_tuser,   // func[0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // pixel_out[0], zero above
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    state_t            state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [COL_W-1:0]  colm1_reg, colm1_next;
    logic              border_reg, border_next;
    logic [2:0]        win0_reg, win0_next;
    logic [2:0]        win1_reg, win1_next;
    logic [2:0]        win2_reg, win2_next;
    logic              m_valid_reg, m_valid_next;
    logic              pixel_reg, pixel_next;
    logic              op_mode_reg;
    logic [MASK_W-1:0] se_mask_reg;

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [BITS_W-1:0] in_bits;
    logic              in_accept;
    logic              out_free;
    logic              is_border;
    logic [WIDTH-1:0]  rd_data;
    logic [WIDTH-1:0]  rd_shift;
    logic [2:0]        rd_win;
    logic              res_now;
    logic              res_done;
    mem_req_t          mem_req;

    assign in_row  = s_tdata[3:0];
    assign in_col  = s_tdata[7:4];
    assign in_bits = s_tdata[23:8];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign is_border = (in_row == '0) || (in_col == '0) ||
                       (in_row >= ROW_LAST) || (in_col >= COL_LAST);

    assign rd_shift = rd_data >> colm1_reg;
    assign rd_win   = rd_shift[2:0];
    assign res_now  = morph_eval({rd_win, win1_reg, win0_reg}, op_mode_reg, se_mask_reg);
    assign res_done = border_reg ? 1'b0
                    : morph_eval({win2_reg, win1_reg, win0_reg}, op_mode_reg, se_mask_reg);

    bed_image_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        colm1_next   = colm1_reg;
        border_next  = border_reg;
        win0_next    = win0_reg;
        win1_next    = win1_reg;
        win2_next    = win2_reg;
        m_valid_next = m_valid_reg && !m_tready;
        pixel_next   = pixel_reg;

        mem_req.we    = 1'b0;
        mem_req.addr  = ADDR_W'(in_row - 1'b1);
        mem_req.wdata = WIDTH'(in_bits);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == FUNC_LOAD)
                    begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = ADDR_W'(in_row);
                    end
                    else
                    begin
                        base_next   = ADDR_W'(in_row - 1'b1);
                        colm1_next  = in_col - 1'b1;
                        cnt_next    = 2'd0;
                        border_next = is_border;
                        state_next  = is_border ? ST_DONE : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // Next row of the window is requested while this one returns.
                mem_req.addr = base_reg + ADDR_W'(cnt_reg) + ADDR_W'(1);
                cnt_next     = cnt_reg + 2'd1;
                unique case (cnt_reg)
                    2'd0:    win0_next = rd_win;
                    2'd1:    win1_next = rd_win;
                    default: win2_next = rd_win;
                endcase
                if (cnt_reg == 2'd2)
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        pixel_next   = res_now;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    pixel_next   = res_done;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
            op_mode_reg <= MODE_ERODE;
            se_mask_reg <= SE_MASK_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OP_MODE: op_mode_reg <= cfg_wdata[0];
                    CFG_SE_MASK: se_mask_reg <= cfg_wdata[MASK_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        colm1_reg  <= colm1_next;
        border_reg <= border_next;
        win0_reg   <= win0_next;
        win1_reg   <= win1_next;
        win2_reg   <= win2_next;
        pixel_reg  <= pixel_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, pixel_reg};

endmodule

FILE: rtl/bed_checker.sv
// Port-level assertions for the binary erode/dilate core and their binding.
module bed_checker
    import bed_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [7:0]        m_tdata
);

    logic query_acc;
    logic load_acc;

    assign query_acc = s_tvalid && s_tready && (s_tuser == FUNC_QUERY);
    assign load_acc  = s_tvalid && s_tready && (s_tuser == FUNC_LOAD);

    // A waiting result is neither withdrawn nor changed.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // A query occupies the core, so the input side is closed for the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> !s_tready)
        else $error("input ready directly after a query");

    // A load gives no result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a load");

    // Padding above the pixel stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:1] == 7'b0))
        else $error("nonzero padding in result");

endmodule

bind binary_erode_dilate_core bed_checker u_bed_checker (.*);
